### sv/crse_pkg.sv
// Shared types, field widths and operation codes of the Catmull-Rom spline evaluator.
package crse_pkg;

   // Field widths of one transfer.
   localparam int OP_W    = 2;
   localparam int COORD_W = 24;
   localparam int SEG_W   = 6;
   localparam int TFRAC_W = 16;
   localparam int ST_W    = 2;
   localparam int REQ_W   = OP_W + 2 * COORD_W + SEG_W + TFRAC_W;

   // Saturation limits of a Q16.8 coordinate.
   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_EVAL   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   // Result status codes.
   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            take;
      logic            append;
      logic            clear;
      logic            st_load;
      logic [ST_W-1:0] st_code;
      logic            idx_open;
      logic            mod_start;
      logic            mod_step;
      logic            idx_loop;
      logic            sq_en;
      logic            tt_en;
      logic            cu_en;
      logic            ttt_en;
      logic            basis_en;
      logic            rd_en;
      logic [1:0]      rd_sel;
      logic            mul_en;
      logic [1:0]      mul_sel;
      logic            acc_load;
      logic            acc_add;
      logic            rsp_load;
   } crse_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            loop_mode;
      logic            full;
      logic            open_ok;
      logic            count_zero;
      logic            out_free;
   } crse_sts_type;

endpackage

### sv/catmull_rom_spline_eval_unit.sv
// Top level of the Catmull-Rom spline evaluator: stream ports, controller and datapath.
// An evaluate takes the bit-serial remainder path (six remainder steps) only for a closed curve.
// One item is in work at a time: a new request is taken in the cycle after the result is loaded,
// and the time per item is set by the shared power multiplier, the four sequential reads of
// the single-port point store and the bit-serial remainder unit.
// Synchronous active-high reset empties the table and clears loop mode and the output valid.
module catmull_rom_spline_eval_unit
   import crse_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int FRAC_BITS   = 16,
   localparam int CW         = $clog2(MAX_ENTRIES + 1),
   localparam int RSP_W      = ((2 * COORD_W + ST_W + CW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   // Configuration: bit 0 is loop_mode.
   input  logic             csr_wen,
   input  logic             csr_wdata,
   // Request stream. tdata fields from bit 0 up: op (2), x_in (24), y_in (24),
   // t_segment (6), t_fraction (16).
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   // Result stream. tdata fields from bit 0 up: x_out (24), y_out (24), status (2),
   // count_out (CW), then zero fill to whole bytes.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   crse_cmd_type cmd;
   crse_sts_type sts;

   logic [OP_W-1:0]           req_op;
   logic signed [COORD_W-1:0] req_x, req_y;
   logic [SEG_W-1:0]          req_seg;
   logic [TFRAC_W-1:0]        req_frac;

   logic signed [COORD_W-1:0] rsp_x, rsp_y;
   logic [ST_W-1:0]           rsp_st;
   logic [CW-1:0]             rsp_count;

   // Unpack the request transfer.
   assign req_op   = req_tdata[OP_W-1:0];
   assign req_x    = req_tdata[OP_W+COORD_W-1:OP_W];
   assign req_y    = req_tdata[OP_W+2*COORD_W-1:OP_W+COORD_W];
   assign req_seg  = req_tdata[OP_W+2*COORD_W+SEG_W-1:OP_W+2*COORD_W];
   assign req_frac = req_tdata[REQ_W-1:OP_W+2*COORD_W+SEG_W];

   // The controller owns the request handshake; it accepts only between items.
   crse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the point store, the arithmetic and the output register,
   // which keeps a finished result until its transfer completes.
   crse_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .FRAC_BITS   (FRAC_BITS),
      .CW          (CW)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .req_op       (req_op),
      .req_x        (req_x),
      .req_y        (req_y),
      .req_seg      (req_seg),
      .req_frac     (req_frac),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid_ff (rsp_tvalid),
      .rsp_x_ff     (rsp_x),
      .rsp_y_ff     (rsp_y),
      .rsp_st_ff    (rsp_st),
      .rsp_count_ff (rsp_count)
   );

   // Pack the result transfer; the upper fill bits are zero.
   assign rsp_tdata = RSP_W'({rsp_count, rsp_st, rsp_y, rsp_x});

endmodule

### sv/crse_ram.sv
// Generic single-port RAM with registered read data.
module crse_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic                     ren,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[addr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

### sv/crse_ctrl.sv
// Controller state machine that sequences one operation at a time.
module crse_ctrl
   import crse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  crse_sts_type sts,
   output crse_cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_IDX    = 3'd3;
   localparam logic [2:0] S_POW    = 3'd4;
   localparam logic [2:0] S_MAC    = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;

   localparam logic [2:0] MOD_LAST = 3'(SEG_W - 1);
   localparam logic [2:0] POW_LAST = 3'd4;
   localparam logic [2:0] MAC_LAST = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] cnt_m1;

   assign req_tready = (state_ff == S_IDLE);
   assign cnt_m1     = cnt_ff - 3'd1;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_OK;
            cnt_in      = 3'd0;
            state_in    = S_FIN;
            unique case (sts.op)
               OP_APPEND: begin
                  if (sts.full) begin
                     cmd.st_code = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               OP_EVAL: begin
                  if (sts.loop_mode) begin
                     if (sts.count_zero) begin
                        cmd.st_code = ST_RANGE;
                     end else begin
                        cmd.mod_start = 1'b1;
                        state_in      = S_MOD;
                     end
                  end else if (sts.open_ok) begin
                     cmd.idx_open = 1'b1;
                     state_in     = S_POW;
                  end else begin
                     cmd.st_code = ST_RANGE;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
                  cmd.st_code = ST_OK;
               end
            endcase
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == MOD_LAST) begin
               state_in = S_IDX;
            end
         end
         S_IDX: begin
            cmd.idx_loop = 1'b1;
            cnt_in       = 3'd0;
            state_in     = S_POW;
         end
         S_POW: begin
            cmd.sq_en    = (cnt_ff == 3'd0);
            cmd.tt_en    = (cnt_ff == 3'd1);
            cmd.cu_en    = (cnt_ff == 3'd2);
            cmd.ttt_en   = (cnt_ff == 3'd3);
            cmd.basis_en = (cnt_ff == POW_LAST);
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == POW_LAST) begin
               cnt_in   = 3'd0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.rd_en    = (cnt_ff <= 3'd3);
            cmd.rd_sel   = cnt_ff[1:0];
            cmd.mul_en   = (cnt_ff >= 3'd1) && (cnt_ff <= 3'd4);
            cmd.mul_sel  = cnt_m1[1:0];
            cmd.acc_load = (cnt_ff == 3'd2);
            cmd.acc_add  = (cnt_ff >= 3'd3);
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == MAC_LAST) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   // The single store port never sees a write and a read together.
   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.append))
      else $error("store write and read in the same cycle");

   // A product is formed only from data read in the previous cycle.
   a_mul_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |-> $past(cmd.rd_en))
      else $error("multiply without a preceding store read");

   // A result is loaded only when the output register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.out_free)
      else $error("result loaded over a pending result");

   // The last remainder step is followed by the index computation.
   a_mod_to_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD && cnt_ff == MOD_LAST) |=> (state_ff == S_IDX))
      else $error("remainder sequence did not end in index step");
`endif

endmodule

### sv/crse_dpath.sv
// Datapath: point store, index logic, power and basis terms, MAC and output register.
module crse_dpath
   import crse_pkg::*;
#(
   parameter int MAX_ENTRIES = 64,
   parameter int FRAC_BITS   = 16,
   parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic                      csr_wdata,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [COORD_W-1:0] req_x,
   input  logic signed [COORD_W-1:0] req_y,
   input  logic [SEG_W-1:0]          req_seg,
   input  logic [TFRAC_W-1:0]        req_frac,
   input  logic                      rsp_tready,
   input  crse_cmd_type              cmd,
   output crse_sts_type              sts,
   output logic                      rsp_valid_ff,
   output logic signed [COORD_W-1:0] rsp_x_ff,
   output logic signed [COORD_W-1:0] rsp_y_ff,
   output logic [ST_W-1:0]           rsp_st_ff,
   output logic [CW-1:0]             rsp_count_ff
);

   localparam int F    = FRAC_BITS;
   localparam int AW   = $clog2(MAX_ENTRIES);
   localparam int EW   = ((CW > SEG_W) ? CW : SEG_W) + 1;
   localparam int QW   = F + 4;
   localparam int PW   = COORD_W + QW;
   localparam int ACCW = PW + 2;
   localparam int RW   = ACCW - F - 1;

   localparam logic [2*F-1:0]        HALF    = (2*F)'(1) << (F - 1);
   localparam logic signed [QW-1:0]  TWO_ONE = QW'(2) << F;
   localparam logic signed [ACCW-1:0] RND    = ACCW'(1) << F;
   localparam logic signed [RW-1:0]  RMAX    = RW'(COORD_MAX);
   localparam logic signed [RW-1:0]  RMIN    = RW'(COORD_MIN);

   // Item registers.
   logic [OP_W-1:0]           op_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [SEG_W-1:0]          seg_ff;
   logic [F-1:0]              t_ff;
   logic [TFRAC_W+F-1:0]      frac_ext;

   logic            loop_mode_ff;
   logic [CW-1:0]   count_ff;
   logic [ST_W-1:0] st_ff;

   // Remainder unit.
   logic [CW-1:0]    rem_ff;
   logic [SEG_W-1:0] sh_ff;
   logic [CW:0]      cand, diff;

   // Point indices.
   logic [AW-1:0] p_ff [4];
   logic [EW-1:0] seg_ext, cnt_ext;
   logic [EW-1:0] open_idx [4];
   logic [CW-1:0] p1w, p2w, p2p, p3w, p3p, p0w;

   // Powers of t.
   logic [2*F-1:0] pw_prod_ff;
   logic [2*F-1:0] pw_rnd;
   logic [F-1:0]   pw_a;
   logic [F-1:0]   tt_ff, ttt_ff;

   // Basis terms and MAC.
   logic signed [QW-1:0]   q_ff [4];
   logic signed [QW-1:0]   ts, tts, ttts, q_sel;
   logic [2*COORD_W-1:0]   ram_rdata;
   logic signed [PW-1:0]   xp_ff, yp_ff;
   logic signed [ACCW-1:0] xacc_ff, yacc_ff, xp_ext, yp_ext;
   logic signed [ACCW-1:0] xb, yb;
   logic signed [RW-1:0]   xr, yr, xs, ys;
   logic [AW-1:0]          ram_addr;

   assign frac_ext = {{F{1'b0}}, req_frac};

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_op;
         x_ff   <= req_x;
         y_ff   <= req_y;
         seg_ff <= req_seg;
         t_ff   <= frac_ext[F-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (csr_wen) begin
            loop_mode_ff <= csr_wdata;
         end
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.append) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.st_load) begin
         st_ff <= cmd.st_code;
      end
   end

   // Open curve: indices seg..seg+3, valid when seg+3 < count.
   assign seg_ext = {{(EW-SEG_W){1'b0}}, seg_ff};
   assign cnt_ext = {{(EW-CW){1'b0}}, count_ff};
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         open_idx[k] = seg_ext + EW'(k);
      end
   end

   // Restoring remainder, one segment bit per step.
   assign cand = {rem_ff, sh_ff[SEG_W-1]};
   assign diff = cand - {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         rem_ff <= '0;
         sh_ff  <= seg_ff;
      end else if (cmd.mod_step) begin
         sh_ff <= {sh_ff[SEG_W-2:0], 1'b0};
         if (cand >= {1'b0, count_ff}) begin
            rem_ff <= diff[CW-1:0];
         end else begin
            rem_ff <= cand[CW-1:0];
         end
      end
   end

   // Closed curve neighbors of the remainder.
   always_comb begin
      p1w = rem_ff;
      p2p = p1w + CW'(1);
      p2w = (p2p == count_ff) ? '0 : p2p;
      p3p = p2w + CW'(1);
      p3w = (p3p == count_ff) ? '0 : p3p;
      p0w = (p1w == '0) ? (count_ff - CW'(1)) : (p1w - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_open) begin
         for (int k = 0; k < 4; k++) begin
            p_ff[k] <= open_idx[k][AW-1:0];
         end
      end else if (cmd.idx_loop) begin
         p_ff[0] <= p0w[AW-1:0];
         p_ff[1] <= p1w[AW-1:0];
         p_ff[2] <= p2w[AW-1:0];
         p_ff[3] <= p3w[AW-1:0];
      end
   end

   // One shared multiplier forms t*t, then tt*t; each product is rounded to Q0.F.
   assign pw_a   = cmd.cu_en ? tt_ff : t_ff;
   assign pw_rnd = pw_prod_ff + HALF;

   always_ff @(posedge clock) begin
      if (cmd.sq_en || cmd.cu_en) begin
         pw_prod_ff <= pw_a * t_ff;
      end
      if (cmd.tt_en) begin
         tt_ff <= pw_rnd[2*F-1:F];
      end
      if (cmd.ttt_en) begin
         ttt_ff <= pw_rnd[2*F-1:F];
      end
   end

   assign ts   = $signed({4'b0000, t_ff});
   assign tts  = $signed({4'b0000, tt_ff});
   assign ttts = $signed({4'b0000, ttt_ff});

   always_ff @(posedge clock) begin
      if (cmd.basis_en) begin
         q_ff[0] <= (tts <<< 1) - ttts - ts;
         q_ff[1] <= (ttts <<< 1) + ttts - (tts <<< 2) - tts + TWO_ONE;
         q_ff[2] <= (tts <<< 2) + ts - (ttts <<< 1) - ttts;
         q_ff[3] <= ttts - tts;
      end
   end

   // Point store: {y, x} per entry.
   assign ram_addr = cmd.append ? count_ff[AW-1:0] : p_ff[cmd.rd_sel];

   crse_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock    (clock),
      .wen      (cmd.append),
      .ren      (cmd.rd_en),
      .addr     (ram_addr),
      .wdata    ({y_ff, x_ff}),
      .rdata_ff (ram_rdata)
   );

   assign q_sel = q_ff[cmd.mul_sel];

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         xp_ff <= $signed(ram_rdata[COORD_W-1:0]) * q_sel;
         yp_ff <= $signed(ram_rdata[2*COORD_W-1:COORD_W]) * q_sel;
      end
   end

   assign xp_ext = $signed({{2{xp_ff[PW-1]}}, xp_ff});
   assign yp_ext = $signed({{2{yp_ff[PW-1]}}, yp_ff});

   always_ff @(posedge clock) begin
      if (cmd.acc_load) begin
         xacc_ff <= xp_ext;
         yacc_ff <= yp_ext;
      end else if (cmd.acc_add) begin
         xacc_ff <= xacc_ff + xp_ext;
         yacc_ff <= yacc_ff + yp_ext;
      end
   end

   // Halve with round half up, then saturate to Q16.8.
   always_comb begin
      xb = xacc_ff + RND;
      yb = yacc_ff + RND;
      xr = xb[ACCW-1:F+1];
      yr = yb[ACCW-1:F+1];
      xs = (xr > RMAX) ? RMAX : ((xr < RMIN) ? RMIN : xr);
      ys = (yr > RMAX) ? RMAX : ((yr < RMIN) ? RMIN : yr);
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (op_ff == OP_EVAL && st_ff == ST_OK) begin
            rsp_x_ff <= xs[COORD_W-1:0];
            rsp_y_ff <= ys[COORD_W-1:0];
         end else begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
         end
         rsp_st_ff    <= st_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign sts.op         = op_ff;
   assign sts.loop_mode  = loop_mode_ff;
   assign sts.full       = (count_ff == CW'(MAX_ENTRIES));
   assign sts.open_ok    = (seg_ext + EW'(3)) < cnt_ext;
   assign sts.count_zero = (count_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

`ifndef NO_ASSERTIONS
   // The point count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("point count beyond table depth");

   // An append is never issued against a full table.
   a_append_full: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !sts.full)
      else $error("append issued on a full table");

   // A loaded result is presented in the next cycle.
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("loaded result not presented");
`endif

endmodule
